@@ hdl/ksm_pkg.sv @@
// Shared constants, types and helpers for the key sequence matcher.
`default_nettype none

package ksm_pkg;

  localparam int ENTRIES   = 64;
  localparam int KEY_BYTES = 8;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int POS_W  = $clog2(KEY_BYTES);
  localparam int CNT_W  = $clog2(ENTRIES + 2);
  localparam int STEP_W = 4;

  localparam logic [7:0] FOLD_TEST = 8'h40;
  localparam logic [7:0] FOLD_BITS = 8'hA0;

  localparam logic [1:0] OP_MATCH = 2'd0;
  localparam logic [1:0] OP_WKEY  = 2'd1;
  localparam logic [1:0] OP_WCODE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] entry_index;
    logic [2:0] byte_position;
    logic [7:0] byte_value;
    logic [7:0] code_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] command_code;
  } res_t;

  typedef logic [KEY_BYTES-1:0][7:0] row_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CMD_VALID,
    C_OP_KEY,
    C_OP_CODE,
    C_OP_NONE,
    C_ZERO_BYTE,
    C_SCAN_MORE,
    C_NOT_FOUND,
    C_LAST_BYTE,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_MORE,
    EMIT_DONE,
    EMIT_MISS
  } emit_t;

  // One control word of the sequencer program.
  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              hold;
    logic              accept;
    logic              wr_key;
    logic              wr_code;
    logic              scan_init;
    logic              scan_adv;
    logic              scan_eval;
    emit_t             emit;
  } ctl_t;

  // Datapath conditions tested by the sequencer.
  typedef struct packed {
    logic cmd_valid;
    logic op_key;
    logic op_code;
    logic op_none;
    logic zero_byte;
    logic scan_more;
    logic found;
    logic next_zero;
    logic out_free;
  } flags_t;

  function automatic logic [7:0] fold(input logic [7:0] b, input logic en);
    return (en && ((b & FOLD_TEST) != 8'h00)) ? (b | FOLD_BITS) : b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ksm_seq.sv @@
// Microcode sequencer: step counter, program ROM and branch logic.
`default_nettype none

module ksm_seq
  import ksm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire flags_t flags,
  output ctl_t        ctl
);

  localparam logic [STEP_W-1:0] S_FETCH     = 4'd0;
  localparam logic [STEP_W-1:0] S_DISP_KEY  = 4'd1;
  localparam logic [STEP_W-1:0] S_DISP_CODE = 4'd2;
  localparam logic [STEP_W-1:0] S_DISP_NONE = 4'd3;
  localparam logic [STEP_W-1:0] S_CHK_ZERO  = 4'd4;
  localparam logic [STEP_W-1:0] S_INIT      = 4'd5;
  localparam logic [STEP_W-1:0] S_PRIME     = 4'd6;
  localparam logic [STEP_W-1:0] S_EVAL      = 4'd7;
  localparam logic [STEP_W-1:0] S_CHK_FOUND = 4'd8;
  localparam logic [STEP_W-1:0] S_CHK_END   = 4'd9;
  localparam logic [STEP_W-1:0] S_MORE      = 4'd10;
  localparam logic [STEP_W-1:0] S_DONE      = 4'd11;
  localparam logic [STEP_W-1:0] S_MISS      = 4'd12;
  localparam logic [STEP_W-1:0] S_WKEY      = 4'd13;
  localparam logic [STEP_W-1:0] S_WCODE     = 4'd14;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              taken;

  // Program ROM.
  always_comb begin
    ctl = '0;
    unique case (step)
      S_FETCH: begin
        ctl.accept = 1'b1;
        ctl.cond   = C_CMD_VALID;
        ctl.target = S_DISP_KEY;
        ctl.hold   = 1'b1;
      end
      S_DISP_KEY: begin
        ctl.cond   = C_OP_KEY;
        ctl.target = S_WKEY;
      end
      S_DISP_CODE: begin
        ctl.cond   = C_OP_CODE;
        ctl.target = S_WCODE;
      end
      S_DISP_NONE: begin
        ctl.cond   = C_OP_NONE;
        ctl.target = S_FETCH;
      end
      S_CHK_ZERO: begin
        ctl.cond   = C_ZERO_BYTE;
        ctl.target = S_MISS;
      end
      S_INIT: begin
        ctl.scan_init = 1'b1;
      end
      S_PRIME: begin
        ctl.scan_adv = 1'b1;
      end
      S_EVAL: begin
        ctl.scan_adv  = 1'b1;
        ctl.scan_eval = 1'b1;
        ctl.cond      = C_SCAN_MORE;
        ctl.target    = S_EVAL;
      end
      S_CHK_FOUND: begin
        ctl.cond   = C_NOT_FOUND;
        ctl.target = S_MISS;
      end
      S_CHK_END: begin
        ctl.cond   = C_LAST_BYTE;
        ctl.target = S_DONE;
      end
      S_MORE: begin
        ctl.emit   = EMIT_MORE;
        ctl.cond   = C_OUT_FREE;
        ctl.target = S_FETCH;
        ctl.hold   = 1'b1;
      end
      S_DONE: begin
        ctl.emit   = EMIT_DONE;
        ctl.cond   = C_OUT_FREE;
        ctl.target = S_FETCH;
        ctl.hold   = 1'b1;
      end
      S_MISS: begin
        ctl.emit   = EMIT_MISS;
        ctl.cond   = C_OUT_FREE;
        ctl.target = S_FETCH;
        ctl.hold   = 1'b1;
      end
      S_WKEY: begin
        ctl.wr_key = 1'b1;
        ctl.cond   = C_ALWAYS;
        ctl.target = S_FETCH;
      end
      S_WCODE: begin
        ctl.wr_code = 1'b1;
        ctl.cond    = C_ALWAYS;
        ctl.target  = S_FETCH;
      end
      default: begin
        ctl.cond   = C_ALWAYS;
        ctl.target = S_FETCH;
      end
    endcase
  end

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_CMD_VALID: taken = flags.cmd_valid;
      C_OP_KEY:    taken = flags.op_key;
      C_OP_CODE:   taken = flags.op_code;
      C_OP_NONE:   taken = flags.op_none;
      C_ZERO_BYTE: taken = flags.zero_byte;
      C_SCAN_MORE: taken = flags.scan_more;
      C_NOT_FOUND: taken = !flags.found;
      C_LAST_BYTE: taken = flags.next_zero;
      C_OUT_FREE:  taken = flags.out_free;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      step_next = ctl.target;
    end else if (ctl.hold) begin
      step_next = step;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ksm_dp.sv @@
// Datapath: command register, key and code stores, scan unit, search state, result register.
`default_nettype none

module ksm_dp
  import ksm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire ctl_t ctl,
  output flags_t    flags,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res,
  input  wire logic cfg_write,
  input  wire logic cfg_data
);

  cmd_t cmd_q;
  logic case_fold;

  row_t             key_mem [ENTRIES];
  logic [ENTRIES-1:0] row_valid;
  logic [7:0]       code_mem [ENTRIES];

  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] rd_idx;
  row_t             rd_row;
  logic             rd_valid;
  logic [7:0]       code_rd;

  logic             found;
  logic [IDX_W-1:0] first;
  logic [7:0]       first_next;
  logic [CNT_W-1:0] end_idx;

  logic             in_seq;
  logic [IDX_W-1:0] group_start;
  logic [CNT_W-1:0] group_end;
  logic [POS_W-1:0] match_pos;

  logic [IDX_W-1:0] wr_addr;
  logic [POS_W-1:0] wr_pos;
  logic             entry_ok;
  logic             key_we;
  logic             code_we;
  logic [IDX_W-1:0] scan_addr;
  row_t             row_eff;
  logic [7:0]       cur_byte;
  logic [POS_W:0]   next_pos;
  logic [7:0]       nxt_byte;
  logic [7:0]       sy;
  logic             hit;
  logic             stop;
  logic [CNT_W-1:0] start;
  logic [CNT_W-1:0] limit;
  logic             out_free;
  logic             commit;

  assign cmd_stall = !ctl.accept;

  always_ff @(posedge clk) begin
    if (ctl.accept && cmd_valid) begin
      cmd_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold <= 1'b0;
    end else if (cfg_write) begin
      case_fold <= cfg_data;
    end
  end

  assign wr_addr  = IDX_W'(cmd_q.entry_index);
  assign wr_pos   = POS_W'(cmd_q.byte_position);
  assign entry_ok = 32'(cmd_q.entry_index) < ENTRIES;
  assign key_we   = ctl.wr_key && entry_ok && (32'(cmd_q.byte_position) < KEY_BYTES);
  assign code_we  = ctl.wr_code && entry_ok;
  assign scan_addr = scan_idx[IDX_W-1:0];

  // A first write to a row zeroes the other bytes of that row.
  always_ff @(posedge clk) begin
    if (key_we) begin
      for (int k = 0; k < KEY_BYTES; k++) begin
        if (!row_valid[wr_addr] || k == int'(wr_pos)) begin
          key_mem[wr_addr][k] <= (k == int'(wr_pos)) ? cmd_q.byte_value : 8'h00;
        end
      end
    end
    rd_row   <= key_mem[scan_addr];
    rd_valid <= row_valid[scan_addr];
    rd_idx   <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (key_we) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[wr_addr] <= cmd_q.code_value;
    end
    code_rd <= code_mem[first];
  end

  assign row_eff  = rd_valid ? rd_row : '0;
  assign cur_byte = row_eff[match_pos];
  assign next_pos = {1'b0, match_pos} + 1'b1;
  assign nxt_byte = (32'(next_pos) < KEY_BYTES) ? row_eff[next_pos[POS_W-1:0]] : 8'h00;

  assign sy    = fold(cmd_q.byte_value, case_fold);
  assign hit   = fold(cur_byte, case_fold) == sy;
  assign start = in_seq ? CNT_W'(group_start) : '0;
  assign limit = in_seq ? group_end : CNT_W'(ENTRIES);
  // Stop at the group end, at the table end or an empty row outside a group, or at the first mismatch after a hit.
  assign stop  = (rd_idx >= limit) || (!in_seq && row_eff[0] == 8'h00) || (found && !hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else begin
      if (ctl.scan_init) begin
        scan_idx <= start;
        found    <= 1'b0;
      end else if (ctl.scan_adv) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (ctl.scan_eval && !stop && !found && hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_eval && !stop && !found && hit) begin
      first      <= rd_idx[IDX_W-1:0];
      first_next <= nxt_byte;
    end
    if (ctl.scan_eval && stop) begin
      end_idx <= rd_idx;
    end
  end

  assign out_free = !res_valid || !res_stall;
  assign commit   = (ctl.emit != EMIT_NONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_seq      <= 1'b0;
      group_start <= '0;
      group_end   <= '0;
      match_pos   <= '0;
    end else if (commit) begin
      if (ctl.emit == EMIT_MORE) begin
        in_seq      <= 1'b1;
        group_start <= first;
        group_end   <= end_idx;
        match_pos   <= match_pos + 1'b1;
      end else begin
        in_seq      <= 1'b0;
        group_start <= '0;
        group_end   <= '0;
        match_pos   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      case (ctl.emit)
        EMIT_MORE: begin
          res.status       <= ST_MORE;
          res.command_code <= 8'h00;
        end
        EMIT_DONE: begin
          res.status       <= ST_DONE;
          res.command_code <= code_rd;
        end
        default: begin
          res.status       <= ST_MISS;
          res.command_code <= 8'h00;
        end
      endcase
    end
  end

  always_comb begin
    flags.cmd_valid = cmd_valid;
    flags.op_key    = cmd_q.op == OP_WKEY;
    flags.op_code   = cmd_q.op == OP_WCODE;
    flags.op_none   = cmd_q.op == OP_NONE;
    flags.zero_byte = cmd_q.byte_value == 8'h00;
    flags.scan_more = !stop;
    flags.found     = found;
    flags.next_zero = first_next == 8'h00;
    flags.out_free  = out_free;
  end

endmodule

`default_nettype wire

@@ hdl/key_sequence_matcher.sv @@
// Top level of the key sequence matcher: sequencer and datapath.
//
//   channel  direction  handshake                word
//   cmd      in         cmd_valid / cmd_stall    cmd_t: op, entry, position, byte, code
//   res      out        res_valid / res_stall    res_t: status, command_code
//   cfg      in         cfg_write                cfg_data: case_fold
//
// A key byte write passes the fetch, key dispatch and key write steps; a code write also passes code dispatch.
// A match byte passes dispatch, the zero check, scan init, prime and evaluation, then the found and
// end checks; the scan reads one key row per cycle from the key store.
// Reset clears the row valid bits; there is no clearing pass.
// A stalled result holds in the output register; the next result waits in its emit step, and no command is accepted.
`default_nettype none

module key_sequence_matcher
  import ksm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res,
  input  wire logic cfg_write,
  input  wire logic cfg_data
);

  ctl_t   ctl;
  flags_t flags;

  ksm_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  ksm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .flags     (flags),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire
